FILE: rtl/ack_pkg.sv
// Shared types and constants of the keyword matcher.
package ack_pkg;

  localparam int unsigned MaxNodesDefault = 256;
  localparam logic [7:0]  DepthSat        = 8'hFF;
  localparam logic [7:0]  LastSym         = 8'hFF;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_BUILD   = 2'd1,
    OP_RESTART = 2'd2,
    OP_SCAN    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_UNBUILT = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_RD,
    ST_INS_EV,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_WALK_RD,
    ST_WALK_EV,
    ST_SCAN_RD,
    ST_SCAN_RES,
    ST_B_INIT,
    ST_B_EDGE_RD,
    ST_B_EDGE_EV,
    ST_B_SET_RD1,
    ST_B_SET_RD2,
    ST_B_SET_WR,
    ST_B_NEXT_U,
    ST_B_POP,
    ST_B_POPF,
    ST_DONE
  } ack_state_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data_byte;
    logic       last;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic       hit;
    logic [7:0] match_depth;
  } res_t;

  // per-node word: pattern end, hit flag, depth
  typedef struct packed {
    logic       ends;
    logic       rep;
    logic [7:0] depth;
  } node_t;

endpackage

FILE: rtl/aho_corasick_keyword_matcher.sv
// Top level of the byte-wise Aho-Corasick keyword matcher.
//
//  channel  valid / ready             payload
//  -------  ------------------------  -----------------------------------
//  in       in_valid_i / in_ready_o    op_i, data_byte_i, last_i
//  out      out_valid_o / out_ready_i  status_o, hit_o, match_depth_o
//
// Restart and an unbuilt scan go straight to the result; an insert that
// ends (last) on an existing node adds a mark step; a scan follows fail
// links until a goto probe succeeds. Build visits each (node, byte) pair, walks
// fail links per trie edge, pops each node; each table has one read port.
// Reset: a clearing pass writes every goto entry with in_ready_o low; the
// node tables are cleared in the same pass.
// Stalls: one item at a time; a finished item waits in the output register
// while the next one is taken, and the engine holds its result if the
// output register is still occupied.
module aho_corasick_keyword_matcher #(
  parameter int unsigned MAX_NODES = ack_pkg::MaxNodesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic       hit_o,
  output logic [7:0] match_depth_o
);
  import ack_pkg::*;

  logic  eng_idle, eng_done, res_ready, start;
  req_t  req;
  res_t  eng_res, out_q;
  logic  out_valid_q, out_valid_d;

  assign in_ready_o = eng_idle;
  assign start      = in_valid_i & eng_idle;
  assign req        = '{op: op_e'(op_i), data_byte: data_byte_i, last: last_i};
  // output register is free or being emptied this cycle
  assign res_ready  = !out_valid_q || out_ready_i;

  ack_engine #(.MAX_NODES(MAX_NODES)) u_engine (
    .clk_i,
    .rst_ni,
    .start_i     (start),
    .req_i       (req),
    .idle_o      (eng_idle),
    .done_o      (eng_done),
    .res_o       (eng_res),
    .res_ready_i (res_ready)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (eng_done && res_ready) out_valid_d = 1'b1;
    else if (out_ready_i)      out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_done && res_ready) out_q <= eng_res;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign hit_o         = out_q.hit;
  assign match_depth_o = out_q.match_depth;

endmodule

FILE: rtl/ack_engine.sv
// Trie, fail-link builder and text walker around the table memories.
module ack_engine #(
  parameter int unsigned MAX_NODES = ack_pkg::MaxNodesDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ack_pkg::req_t req_i,
  output logic          idle_o,
  output logic          done_o,
  output ack_pkg::res_t res_o,
  input  logic          res_ready_i
);
  import ack_pkg::*;

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned CW = NW + 1;
  localparam int unsigned GA = NW + 8;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_NODES);

  // memories
  logic [NW-1:0] gmem [MAX_NODES*256];
  logic [NW-1:0] fmem [MAX_NODES];
  node_t         nmem [MAX_NODES];
  logic [NW-1:0] qmem [MAX_NODES];

  logic          g_we, f_we, n_we, q_we;
  logic [GA-1:0] g_waddr, g_raddr;
  logic [NW-1:0] g_wdata, gdata_q;
  logic [NW-1:0] f_waddr, f_raddr, f_wdata, fdata_q;
  logic [NW-1:0] n_waddr, n_raddr;
  node_t         n_wdata, ndata_q;
  logic [NW-1:0] q_waddr, q_raddr, q_wdata, qdata_q;

  ack_state_e    state_q, state_d;
  op_e           op_q, op_d;
  logic [7:0]    byte_q, byte_d, c_q, c_d;
  logic          last_q, last_d, built_q, built_d, root_q, root_d, repf_q, repf_d;
  logic [NW-1:0] cur_q, cur_d, scan_q, scan_d, s_q, s_d, u_q, u_d;
  logic [NW-1:0] fu_q, fu_d, v_q, v_d, f_q, f_d;
  logic [CW-1:0] count_q, count_d, head_q, head_d, tail_q, tail_d;
  logic [GA-1:0] clr_q, clr_d;
  res_t          res_q, res_d;

  logic          found, tail_full;
  logic [7:0]    sym, dsat;

  assign sym       = (op_q == OP_BUILD) ? c_q : byte_q;
  assign found     = (gdata_q != '0) || (s_q == '0);
  assign tail_full = (tail_q >= MaxCnt);
  assign dsat      = (ndata_q.depth == DepthSat) ? DepthSat : ndata_q.depth + 8'd1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:     if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE: begin
        if (start_i) begin
          case (req_i.op)
            OP_INSERT:  state_d = ST_INS_RD;
            OP_BUILD:   state_d = ST_B_INIT;
            OP_RESTART: state_d = ST_DONE;
            OP_SCAN:    state_d = built_q ? ST_WALK_RD : ST_DONE;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_INS_RD:    state_d = ST_INS_EV;
      ST_INS_EV:    state_d = (gdata_q != '0 && last_q) ? ST_MARK_RD : ST_DONE;
      ST_MARK_RD:   state_d = ST_MARK_WR;
      ST_MARK_WR:   state_d = ST_DONE;
      ST_WALK_RD:   state_d = ST_WALK_EV;
      ST_WALK_EV: begin
        if (found) state_d = (op_q == OP_BUILD) ? ST_B_SET_RD1 : ST_SCAN_RD;
        else       state_d = ST_WALK_RD;
      end
      ST_SCAN_RD:   state_d = ST_SCAN_RES;
      ST_SCAN_RES:  state_d = ST_DONE;
      ST_B_INIT:    state_d = ST_B_EDGE_RD;
      ST_B_EDGE_RD: state_d = ST_B_EDGE_EV;
      ST_B_EDGE_EV: begin
        if (gdata_q == '0 || tail_full)
          state_d = (c_q == LastSym) ? ST_B_NEXT_U : ST_B_EDGE_RD;
        else
          state_d = root_q ? ST_B_SET_RD1 : ST_WALK_RD;
      end
      ST_B_SET_RD1: state_d = ST_B_SET_RD2;
      ST_B_SET_RD2: state_d = ST_B_SET_WR;
      ST_B_SET_WR:  state_d = (c_q == LastSym) ? ST_B_NEXT_U : ST_B_EDGE_RD;
      ST_B_NEXT_U:  state_d = (head_q < tail_q) ? ST_B_POP : ST_DONE;
      ST_B_POP:     state_d = ST_B_POPF;
      ST_B_POPF:    state_d = ST_B_EDGE_RD;
      ST_DONE:      if (res_ready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_d = op_q; byte_d = byte_q; last_d = last_q; c_d = c_q;
    built_d = built_q; root_d = root_q; repf_d = repf_q;
    cur_d = cur_q; scan_d = scan_q; s_d = s_q; u_d = u_q; fu_d = fu_q;
    v_d = v_q; f_d = f_q; count_d = count_q; head_d = head_q; tail_d = tail_q;
    clr_d = clr_q; res_d = res_q;
    g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_raddr = {s_q, sym};
    f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = s_q;
    n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_raddr = s_q;
    q_we = 1'b0; q_waddr = tail_q[NW-1:0]; q_wdata = v_q; q_raddr = head_q[NW-1:0];
    case (state_q)
      ST_CLEAR: begin
        g_we = 1'b1; g_waddr = clr_q;
        f_we = 1'b1; f_waddr = clr_q[NW-1:0];
        n_we = 1'b1; n_waddr = clr_q[NW-1:0];
        clr_d = clr_q + GA'(1);
      end
      ST_IDLE: begin
        if (start_i) begin
          op_d = req_i.op; byte_d = req_i.data_byte; last_d = req_i.last;
          res_d = '0;
          s_d = scan_q;
          case (req_i.op)
            OP_INSERT:  built_d = 1'b0;
            OP_RESTART: scan_d = '0;
            OP_SCAN:    if (!built_q) res_d.status = STAT_UNBUILT;
            default:    ;
          endcase
        end
      end
      ST_INS_RD: begin
        g_raddr = {cur_q, byte_q};
        n_raddr = cur_q;
      end
      ST_INS_EV: begin
        if (gdata_q == '0) begin
          if (count_q < MaxCnt) begin
            g_we = 1'b1; g_waddr = {cur_q, byte_q}; g_wdata = count_q[NW-1:0];
            n_we = 1'b1; n_waddr = count_q[NW-1:0];
            n_wdata = '{ends: last_q, rep: 1'b0, depth: dsat};
            f_we = 1'b1; f_waddr = count_q[NW-1:0];
            cur_d = last_q ? '0 : count_q[NW-1:0];
            count_d = count_q + CW'(1);
          end else begin
            res_d.status = STAT_FULL;
            if (last_q) cur_d = '0;
          end
        end else begin
          cur_d = last_q ? '0 : gdata_q;
          v_d = gdata_q;
        end
      end
      ST_MARK_RD: n_raddr = v_q;
      ST_MARK_WR: begin
        n_we = 1'b1; n_waddr = v_q;
        n_wdata = '{ends: 1'b1, rep: ndata_q.rep, depth: ndata_q.depth};
      end
      ST_WALK_EV: begin
        if (found) begin
          if (op_q == OP_BUILD) f_d = gdata_q;
          else                  s_d = gdata_q;
        end else begin
          s_d = fdata_q;
        end
      end
      ST_SCAN_RES: begin
        scan_d = s_q;
        res_d.hit = ndata_q.rep;
        res_d.match_depth = ndata_q.depth;
      end
      ST_B_INIT: begin
        f_we = 1'b1; f_waddr = '0;
        n_we = 1'b1; n_waddr = '0;
        head_d = '0; tail_d = '0; u_d = '0; root_d = 1'b1; c_d = '0;
      end
      ST_B_EDGE_RD: g_raddr = {u_q, c_q};
      ST_B_EDGE_EV: begin
        if (gdata_q == '0 || tail_full) begin
          c_d = c_q + 8'd1;
        end else begin
          v_d = gdata_q;
          f_d = '0;
          s_d = fu_q;
        end
      end
      ST_B_SET_RD1: n_raddr = f_q;
      ST_B_SET_RD2: begin
        n_raddr = v_q;
        repf_d = ndata_q.rep;
      end
      ST_B_SET_WR: begin
        n_we = 1'b1; n_waddr = v_q;
        n_wdata = '{ends: ndata_q.ends, rep: ndata_q.ends | repf_q, depth: ndata_q.depth};
        f_we = 1'b1; f_waddr = v_q; f_wdata = f_q;
        q_we = 1'b1;
        tail_d = tail_q + CW'(1);
        c_d = c_q + 8'd1;
      end
      ST_B_NEXT_U: begin
        if (head_q < tail_q) begin
          head_d = head_q + CW'(1);
        end else begin
          built_d = 1'b1;
          scan_d = '0;
        end
      end
      ST_B_POP: begin
        u_d = qdata_q; root_d = 1'b0;
        f_raddr = qdata_q;
      end
      ST_B_POPF: begin
        fu_d = fdata_q; c_d = '0;
      end
      default: ;
    endcase
  end

  assign idle_o = (state_q == ST_IDLE);
  assign done_o = (state_q == ST_DONE);
  assign res_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      built_q <= 1'b0;
      cur_q   <= '0;
      scan_q  <= '0;
      count_q <= CW'(1);
      head_q  <= '0;
      tail_q  <= '0;
      root_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      built_q <= built_d;
      cur_q   <= cur_d;
      scan_q  <= scan_d;
      count_q <= count_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      root_q  <= root_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; byte_q <= byte_d; last_q <= last_d; c_q <= c_d;
    repf_q <= repf_d; s_q <= s_d; u_q <= u_d; fu_q <= fu_d;
    v_q <= v_d; f_q <= f_d; res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (g_we) gmem[g_waddr] <= g_wdata;
    gdata_q <= gmem[g_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (f_we) fmem[f_waddr] <= f_wdata;
    fdata_q <= fmem[f_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (n_we) nmem[n_waddr] <= n_wdata;
    ndata_q <= nmem[n_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) qmem[q_waddr] <= q_wdata;
    qdata_q <= qmem[q_raddr];
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt && count_q != '0) else $error("node count out of range");
  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("queue head passed tail");
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_q.status == STAT_FULL |-> count_q == MaxCnt)
    else $error("full reported with free nodes");
  a_built_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(built_q) |-> $past(state_q == ST_B_NEXT_U))
    else $error("built set outside build");
`endif

endmodule
